>>> src/sepwm_pkg.sv
// ----------------------------------------------------------------------------
// sepwm_pkg
// Shared types, codes and constants for the servo / motor pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sepwm_pkg;

  // Default widths of compare and timer registers
  localparam int DEF_COMPARE_WIDTH = 12;
  localparam int DEF_COUNTER_WIDTH = 16;

  // Operation codes of an input word
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_PITCH    = 3'd1;
  localparam logic [2:0] OP_YAW      = 3'd2;
  localparam logic [2:0] OP_ROLL     = 3'd3;
  localparam logic [2:0] OP_THROTTLE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_PERIOD    = 3'd0;
  localparam logic [2:0] CFG_SERVO_MIN = 3'd1;
  localparam logic [2:0] CFG_SERVO_MAX = 3'd2;
  localparam logic [2:0] CFG_ESC_MIN   = 3'd3;
  localparam logic [2:0] CFG_ESC_MAX   = 3'd4;

  // Configuration reset values
  localparam logic [15:0] RST_PERIOD    = 16'd20000;
  localparam logic [11:0] RST_SERVO_MIN = 12'd500;
  localparam logic [11:0] RST_SERVO_MAX = 12'd2500;
  localparam logic [11:0] RST_ESC_MIN   = 12'd1000;
  localparam logic [11:0] RST_ESC_MAX   = 12'd2000;

  // Compare reset values
  localparam int RST_SERVO_CMP = 1500;
  localparam int RST_MOTOR_CMP = 1000;

  // Channel slots
  localparam int CH_ELEVATOR = 0;
  localparam int CH_RUDDER   = 1;
  localparam int CH_LAIL     = 2;
  localparam int CH_RAIL     = 3;
  localparam int CH_MOTOR    = 4;
  localparam int CH_COUNT    = 5;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Product width: 16-bit offset command times 12-bit span
  localparam int PROD_WIDTH = 28;

  // ceil(2^28 / 255): exact floor(q/255) for q below 2^20
  localparam logic [20:0] RECIP_255 = 21'd1052689;
  localparam int RECIP_SHIFT = 28;

  typedef enum logic [2:0] {
    K_TICK,
    K_PITCH,
    K_YAW,
    K_ROLL,
    K_THROTTLE,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] command_value;
  } in_item_t;

  typedef struct packed {
    logic        elevator_level;
    logic        rudder_level;
    logic        left_aileron_level;
    logic        right_aileron_level;
    logic        motor_level;
    logic        frame_start;
    logic [15:0] tick_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tmr_period;
    logic [11:0] srv_lo_us;
    logic [11:0] srv_hi_us;
    logic [11:0] mot_lo_us;
    logic [11:0] mot_hi_us;
  } cfg_t;

  // Classified word waiting for the back end
  typedef struct packed {
    kind_t                 kind;
    logic                  neg;
    logic [PROD_WIDTH-1:0] prod;
  } qentry_t;

endpackage

`default_nettype wire

>>> src/sepwm_front.sv
// ----------------------------------------------------------------------------
// sepwm_front
// Classifies an input word and forms the magnitude of the mapping product.
// ----------------------------------------------------------------------------
`default_nettype none

module sepwm_front (
  input  var sepwm_pkg::in_item_t item,
  input  var sepwm_pkg::cfg_t     cfg,
  output sepwm_pkg::qentry_t      entry
);
  import sepwm_pkg::*;

  kind_t       kind;
  logic [15:0] offset_cmd;
  logic [7:0]  throttle;
  logic        servo_neg;
  logic        esc_neg;
  logic [11:0] servo_span;
  logic [11:0] esc_span;
  logic [15:0] mul_a;
  logic [11:0] mul_b;

  // Decode operation
  always_comb begin
    unique case (item.operation)
      OP_TICK:     kind = K_TICK;
      OP_PITCH:    kind = K_PITCH;
      OP_YAW:      kind = K_YAW;
      OP_ROLL:     kind = K_ROLL;
      OP_THROTTLE: kind = K_THROTTLE;
      default:     kind = K_NONE;
    endcase
  end

  // Command + 32768, and throttle clamped to 0..255
  assign offset_cmd = {~item.command_value[15], item.command_value[14:0]};

  always_comb begin
    priority if (item.command_value[15]) begin
      throttle = 8'd0;
    end else if (|item.command_value[14:8]) begin
      throttle = 8'd255;
    end else begin
      throttle = item.command_value[7:0];
    end
  end

  // Span magnitude and sign, left-side orientation
  assign servo_neg  = cfg.srv_hi_us < cfg.srv_lo_us;
  assign esc_neg    = cfg.mot_hi_us < cfg.mot_lo_us;
  assign servo_span = servo_neg ? (cfg.srv_lo_us - cfg.srv_hi_us)
                                : (cfg.srv_hi_us - cfg.srv_lo_us);
  assign esc_span   = esc_neg ? (cfg.mot_lo_us - cfg.mot_hi_us)
                              : (cfg.mot_hi_us - cfg.mot_lo_us);

  // One shared multiplier
  always_comb begin
    if (kind == K_THROTTLE) begin
      mul_a = {8'd0, throttle};
      mul_b = esc_span;
    end else begin
      mul_a = offset_cmd;
      mul_b = servo_span;
    end
  end

  assign entry.kind = kind;
  assign entry.neg  = (kind == K_THROTTLE) ? esc_neg : servo_neg;
  assign entry.prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

endmodule

`default_nettype wire

>>> src/sepwm_queue.sv
// ----------------------------------------------------------------------------
// sepwm_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sepwm_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  var sepwm_pkg::qentry_t push_entry,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output sepwm_pkg::qentry_t  head
);
  import sepwm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> src/sepwm_back.sv
// ----------------------------------------------------------------------------
// sepwm_back
// Finishes the mapping division, keeps the compares, runs the timer and
// holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sepwm_back #(
  parameter int COMPARE_WIDTH = sepwm_pkg::DEF_COMPARE_WIDTH,
  parameter int COUNTER_WIDTH = sepwm_pkg::DEF_COUNTER_WIDTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  var sepwm_pkg::cfg_t  cfg,
  input  wire                  head_valid,
  input  var sepwm_pkg::qentry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sepwm_pkg::out_item_t out_item
);
  import sepwm_pkg::*;

  localparam int CMPW = (COUNTER_WIDTH > COMPARE_WIDTH) ? COUNTER_WIDTH : COMPARE_WIDTH;
  localparam int PERW = ((COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16) + 1;
  localparam logic [COMPARE_WIDTH-1:0] SERVO_CMP_RST = COMPARE_WIDTH'(RST_SERVO_CMP);
  localparam logic [COMPARE_WIDTH-1:0] MOTOR_CMP_RST = COMPARE_WIDTH'(RST_MOTOR_CMP);

  logic [COUNTER_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [CH_COUNT-1:0]      pins_r, pins_nxt;
  logic [COMPARE_WIDTH-1:0] shadow_r [CH_COUNT];
  logic [COMPARE_WIDTH-1:0] shadow_nxt [CH_COUNT];
  logic [COMPARE_WIDTH-1:0] active_r [CH_COUNT];
  logic [COMPARE_WIDTH-1:0] active_nxt [CH_COUNT];
  logic [COMPARE_WIDTH-1:0] eff_cmp [CH_COUNT];
  out_item_t                out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [40:0]        esc_prod;
  logic [11:0]        esc_quot;
  logic [28:0]        servo_sum;
  logic [11:0]        servo_quot;
  logic [11:0]        quot;
  logic signed [13:0] signed_quot;
  logic [11:0]        lo_bound;
  logic signed [13:0] left_sum;
  logic signed [13:0] right_sum;
  logic [31:0]        left_wide;
  logic [31:0]        right_wide;
  logic [COMPARE_WIDTH-1:0] left_cmp;
  logic [COMPARE_WIDTH-1:0] right_cmp;
  logic               at_zero;
  logic [PERW-1:0]    cnt_inc;
  logic [31:0]        used_wide;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Division by 255 (throttle) via reciprocal, by 65535 (servo) via fold-add
  assign esc_prod   = 41'(head.prod[19:0]) * 41'(RECIP_255);
  assign esc_quot   = esc_prod[RECIP_SHIFT+11:RECIP_SHIFT];
  assign servo_sum  = 29'(head.prod) + 29'(head.prod[PROD_WIDTH-1:16]) + 29'd1;
  assign servo_quot = servo_sum[27:16];
  assign quot       = (head.kind == K_THROTTLE) ? esc_quot : servo_quot;
  assign signed_quot = head.neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

  // Mapped values: left/normal side from the low bound, right side inverted
  assign lo_bound  = (head.kind == K_THROTTLE) ? cfg.mot_lo_us : cfg.srv_lo_us;
  assign left_sum  = $signed({2'b00, lo_bound}) + signed_quot;
  assign right_sum = $signed({2'b00, cfg.srv_hi_us}) - signed_quot;
  assign left_wide  = 32'(left_sum[11:0]);
  assign right_wide = 32'(right_sum[11:0]);
  assign left_cmp   = left_wide[COMPARE_WIDTH-1:0];
  assign right_cmp  = right_wide[COMPARE_WIDTH-1:0];

  // Timer view for this word
  assign at_zero   = (cnt_r == '0);
  assign cnt_inc   = PERW'(cnt_r) + PERW'(1);
  assign used_wide = 32'(cnt_r);

  always_comb begin
    for (int i = 0; i < CH_COUNT; i++) begin
      eff_cmp[i] = at_zero ? shadow_r[i] : active_r[i];
    end
  end

  // Word execution
  always_comb begin
    cnt_nxt       = cnt_r;
    pins_nxt      = pins_r;
    shadow_nxt    = shadow_r;
    active_nxt    = active_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      unique case (head.kind)
        K_TICK: begin
          if (at_zero) begin
            active_nxt = shadow_r;
          end
          for (int i = 0; i < CH_COUNT; i++) begin
            pins_nxt[i] = CMPW'(cnt_r) < CMPW'(eff_cmp[i]);
          end
          if (cnt_inc >= PERW'(cfg.tmr_period)) begin
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_inc[COUNTER_WIDTH-1:0];
          end
        end
        K_PITCH:    shadow_nxt[CH_ELEVATOR] = left_cmp;
        K_YAW:      shadow_nxt[CH_RUDDER]   = left_cmp;
        K_ROLL: begin
          shadow_nxt[CH_LAIL] = left_cmp;
          shadow_nxt[CH_RAIL] = right_cmp;
        end
        K_THROTTLE: shadow_nxt[CH_MOTOR] = left_cmp;
        default: ;
      endcase
      out_valid_nxt                = 1'b1;
      out_nxt.elevator_level       = pins_nxt[CH_ELEVATOR];
      out_nxt.rudder_level         = pins_nxt[CH_RUDDER];
      out_nxt.left_aileron_level   = pins_nxt[CH_LAIL];
      out_nxt.right_aileron_level  = pins_nxt[CH_RAIL];
      out_nxt.motor_level          = pins_nxt[CH_MOTOR];
      out_nxt.frame_start          = (head.kind == K_TICK) && at_zero;
      out_nxt.tick_count           = used_wide[15:0];
    end
  end

  // Control and compare state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CH_COUNT; i++) begin
        shadow_r[i] <= (i == CH_MOTOR) ? MOTOR_CMP_RST : SERVO_CMP_RST;
        active_r[i] <= (i == CH_MOTOR) ? MOTOR_CMP_RST : SERVO_CMP_RST;
      end
    end else begin
      cnt_r       <= cnt_nxt;
      pins_r      <= pins_nxt;
      out_valid_r <= out_valid_nxt;
      shadow_r    <= shadow_nxt;
      active_r    <= active_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

>>> src/servo_esc_pwm_generator.sv
// ----------------------------------------------------------------------------
// servo_esc_pwm_generator
// Five-channel servo / motor pulse generator on one microsecond timer.
//
// Input words (in_valid/in_stall) carry a tick or an axis command. A tick
// advances the timer over 0..period-1 and samples the five pin levels; at
// count zero the shadow compares load into the active ones. Commands map
// onto a shadow compare (roll sets both ailerons, the right one inverted).
// Every word yields one result word on out_valid/out_stall.
// out_valid rises once an accepted word has passed through the front-to-back
// queue and been loaded into the output register. One word per cycle passes
// while the output is not stalled, set by the single execution stage in the
// back end. A stalled output holds its word; the two-entry queue keeps
// taking input until it fills, then in_stall rises.
// Configuration writes (cfg_valid/cfg_ready) are taken every cycle; the user
// must issue them only while the block is idle, and the block itself does
// not enforce this.
// Reset: timer at zero, pins low, compares 1500 us (servos) and 1000 us
// (motor), registers at 20000 / 500 / 2500 / 1000 / 2000.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_esc_pwm_generator #(
  parameter int COMPARE_WIDTH = sepwm_pkg::DEF_COMPARE_WIDTH,
  parameter int COUNTER_WIDTH = sepwm_pkg::DEF_COUNTER_WIDTH
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  var sepwm_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sepwm_pkg::out_item_t out_item,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [2:0]           cfg_index,
  input  wire  [15:0]          cfg_data
);
  import sepwm_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  qentry_t front_entry;
  qentry_t head;
  logic    q_full;
  logic    head_valid;
  logic    pop;
  logic    push;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD:    cfg_nxt.tmr_period = cfg_data;
        CFG_SERVO_MIN: cfg_nxt.srv_lo_us  = cfg_data[11:0];
        CFG_SERVO_MAX: cfg_nxt.srv_hi_us  = cfg_data[11:0];
        CFG_ESC_MIN:   cfg_nxt.mot_lo_us  = cfg_data[11:0];
        CFG_ESC_MAX:   cfg_nxt.mot_hi_us  = cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tmr_period <= RST_PERIOD;
      cfg_r.srv_lo_us  <= RST_SERVO_MIN;
      cfg_r.srv_hi_us  <= RST_SERVO_MAX;
      cfg_r.mot_lo_us  <= RST_ESC_MIN;
      cfg_r.mot_hi_us  <= RST_ESC_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: decode and multiply
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  sepwm_front u_front (
    .item  (in_item),
    .cfg   (cfg_r),
    .entry (front_entry)
  );

  sepwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: divide, compares, timer, output register
  sepwm_back #(
    .COMPARE_WIDTH (COMPARE_WIDTH),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef SYNTH
  // A frame start always reports count zero
  a_frame_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_start |-> out_item.tick_count == 16'd0)
    else $error("frame_start with nonzero tick_count");

  // A full queue only happens behind a stalled output word
  a_full_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> out_valid)
    else $error("queue full while output register empty");

  // The back end never pops an empty queue
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> tb/sv/servo_esc_pwm_generator_tb.sv
// ----------------------------------------------------------------------------
// servo_esc_pwm_generator_tb
// Self-checking bench for the five-channel servo / motor pulse generator.
// A clocked driver feeds tick and command words from a queue; a clocked
// monitor checks every result word against a built-in timer/compare model.
// The run steps through several timer and pulse-range settings written
// between phases, with random gaps on both sides, and two long output holds
// that fill the block and back up its input.
// ----------------------------------------------------------------------------

module servo_esc_pwm_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sepwm_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_WORDS = 78;

  typedef struct packed {
    logic [2:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Stimulus and expectation stores
  in_item_t   word_queue[$];
  reg_write_t reg_queue[$];
  out_item_t  pending_levels[$];
  reg_write_t reg_next;
  out_item_t  level_want;

  // Model of the timer and compares
  cfg_t        cfg_copy;
  logic [15:0] tmr_count;
  logic [11:0] shadow_cmp[CH_COUNT];
  logic [11:0] active_cmp[CH_COUNT];
  logic [4:0]  pins;

  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int fail_count = 0;

  servo_esc_pwm_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Linear map with clamp; division truncates toward zero
  function automatic logic [11:0] scale_cmd(longint x, longint in_lo, longint in_hi,
                                            longint out_lo, longint out_hi);
    longint r;
    if (x < in_lo) x = in_lo;
    if (x > in_hi) x = in_hi;
    r = (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    return r[11:0];
  endfunction

  task automatic reset_model();
    cfg_copy = '{RST_PERIOD, RST_SERVO_MIN, RST_SERVO_MAX, RST_ESC_MIN, RST_ESC_MAX};
    tmr_count = '0;
    pins = '0;
    for (int i = 0; i < CH_COUNT; i++) begin
      shadow_cmp[i] = (i == CH_MOTOR) ? 12'(RST_MOTOR_CMP) : 12'(RST_SERVO_CMP);
      active_cmp[i] = shadow_cmp[i];
    end
  endtask

  // Advance the model by one input word, return the expected result word
  function automatic out_item_t pulse_step(in_item_t w);
    out_item_t   r;
    logic [15:0] used;
    logic        frame;
    longint      cmd;
    used = tmr_count;
    frame = 1'b0;
    cmd = $signed(w.command_value);
    case (w.operation)
      OP_TICK: begin
        if (used == 16'd0) begin
          frame = 1'b1;
          for (int i = 0; i < CH_COUNT; i++) active_cmp[i] = shadow_cmp[i];
        end
        for (int i = 0; i < CH_COUNT; i++) pins[i] = (used < active_cmp[i]);
        if (int'(used) + 1 >= int'(cfg_copy.tmr_period)) tmr_count = '0;
        else tmr_count = used + 16'd1;
      end
      OP_PITCH: begin
        shadow_cmp[CH_ELEVATOR] = scale_cmd(cmd, -32768, 32767,
                                            cfg_copy.srv_lo_us, cfg_copy.srv_hi_us);
      end
      OP_YAW: begin
        shadow_cmp[CH_RUDDER] = scale_cmd(cmd, -32768, 32767,
                                          cfg_copy.srv_lo_us, cfg_copy.srv_hi_us);
      end
      OP_ROLL: begin
        shadow_cmp[CH_LAIL] = scale_cmd(cmd, -32768, 32767,
                                        cfg_copy.srv_lo_us, cfg_copy.srv_hi_us);
        // right aileron runs the other way
        shadow_cmp[CH_RAIL] = scale_cmd(cmd, -32768, 32767,
                                        cfg_copy.srv_hi_us, cfg_copy.srv_lo_us);
      end
      OP_THROTTLE: begin
        shadow_cmp[CH_MOTOR] = scale_cmd(cmd, 0, 255, cfg_copy.mot_lo_us, cfg_copy.mot_hi_us);
      end
      default: ;
    endcase
    r.elevator_level      = pins[CH_ELEVATOR];
    r.rudder_level        = pins[CH_RUDDER];
    r.left_aileron_level  = pins[CH_LAIL];
    r.right_aileron_level = pins[CH_RAIL];
    r.motor_level         = pins[CH_MOTOR];
    r.frame_start         = frame;
    r.tick_count          = used;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Input driver: predicts on acceptance, holds a stalled word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_levels.push_back(pulse_step(in_item));
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && !($urandom_range(0, 99) < send_gap_pct)) begin
          in_valid <= 1'b1;
          in_item <= word_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          $error("result word with nothing expected, tick_count %0d", out_item.tick_count);
          fail_count++;
        end else begin
          level_want = pending_levels.pop_front();
          check_field("elevator_level", level_want.elevator_level, out_item.elevator_level);
          check_field("rudder_level", level_want.rudder_level, out_item.rudder_level);
          check_field("left_aileron_level", level_want.left_aileron_level,
                      out_item.left_aileron_level);
          check_field("right_aileron_level", level_want.right_aileron_level,
                      out_item.right_aileron_level);
          check_field("motor_level", level_want.motor_level, out_item.motor_level);
          check_field("frame_start", level_want.frame_start, out_item.frame_start);
          check_field("tick_count", level_want.tick_count, out_item.tick_count);
        end
      end
      // long hold on request, else random stalls
      if (hold_asked != hold_seen) begin
        hold_seen <= hold_asked;
        hold_cnt <= HOLD_CYCLES;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Register writer; the model copy follows each accepted write
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PERIOD:    cfg_copy.tmr_period = cfg_data;
          CFG_SERVO_MIN: cfg_copy.srv_lo_us = cfg_data[11:0];
          CFG_SERVO_MAX: cfg_copy.srv_hi_us = cfg_data[11:0];
          CFG_ESC_MIN:   cfg_copy.mot_lo_us = cfg_data[11:0];
          CFG_ESC_MAX:   cfg_copy.mot_hi_us = cfg_data[11:0];
          default: ;
        endcase
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_queue.size() > 0) begin
          reg_next = reg_queue.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= reg_next.idx;
          cfg_data <= reg_next.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (!(word_queue.size() == 0 && !in_valid && pending_levels.size() == 0))
      @(negedge clk);
  endtask

  task automatic apply_setting(int period, int smin, int smax, int emin, int emax);
    wait_drain();
    reg_queue.push_back('{CFG_PERIOD, 16'(period)});
    reg_queue.push_back('{CFG_SERVO_MIN, 16'(smin)});
    reg_queue.push_back('{CFG_SERVO_MAX, 16'(smax)});
    reg_queue.push_back('{CFG_ESC_MIN, 16'(emin)});
    reg_queue.push_back('{CFG_ESC_MAX, 16'(emax)});
    while (reg_queue.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic push_word(logic [2:0] op, int val);
    in_item_t w;
    w.operation = op;
    w.command_value = 16'(val);
    word_queue.push_back(w);
  endtask

  function automatic int random_cmd();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3, 4, 5: return int'($urandom_range(0, 300)) - 20;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly ticks, commands mixed in, a few unused codes
  task automatic random_phase(int send_p, int stall_p, bit hold);
    int       counted;
    int       pick;
    in_item_t w;
    counted = 0;
    send_gap_pct <= send_p;
    stall_pct <= stall_p;
    while (counted < PHASE_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      w.operation = OP_TICK;
      else if (pick < 65) w.operation = OP_PITCH;
      else if (pick < 73) w.operation = OP_YAW;
      else if (pick < 83) w.operation = OP_ROLL;
      else if (pick < 93) w.operation = OP_THROTTLE;
      else                w.operation = 3'($urandom_range(5, 7));
      w.command_value = 16'(random_cmd());
      word_queue.push_back(w);
      if (w.operation <= OP_THROTTLE) counted++;
    end
    if (hold) hold_asked <= hold_asked + 1;
    wait_drain();
  endtask

  initial begin
    int period;
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of every command at reset settings, unused codes
    push_word(OP_TICK, 0);
    push_word(OP_TICK, -1);
    push_word(OP_PITCH, -32768);
    push_word(OP_PITCH, 32767);
    push_word(OP_YAW, 0);
    push_word(OP_ROLL, -32768);
    push_word(OP_ROLL, 32767);
    push_word(OP_ROLL, -1);
    push_word(OP_THROTTLE, -32768);
    push_word(OP_THROTTLE, 0);
    push_word(OP_THROTTLE, 255);
    push_word(OP_THROTTLE, 32767);
    push_word(3'd5, -32768);
    push_word(3'd6, 32767);
    push_word(3'd7, -1);
    push_word(OP_TICK, 0);

    // Period one after a larger count: wrap, then a frame every tick;
    // compare zero on the elevator, inverted motor range
    apply_setting(1, 0, 4095, 4095, 0);
    push_word(OP_TICK, 0);
    push_word(OP_TICK, 0);
    push_word(OP_PITCH, -32768);
    push_word(OP_ROLL, 32767);
    push_word(OP_THROTTLE, 255);
    push_word(OP_TICK, 0);
    push_word(OP_TICK, 0);

    // Period zero, equal bounds
    apply_setting(0, 700, 700, 0, 0);
    push_word(OP_ROLL, 12345);
    push_word(OP_THROTTLE, 77);
    push_word(OP_TICK, 0);
    push_word(OP_TICK, 0);

    // Random phases over fixed corner settings, then random ones
    apply_setting(2, 0, 4095, 0, 4095);
    random_phase(0, 0, 1'b1);
    apply_setting(65535, 4095, 0, 4095, 0);
    random_phase(47, 0, 1'b0);
    apply_setting(200, 20, 180, 180, 20);
    random_phase(0, 47, 1'b0);
    // shrink below the running count
    apply_setting(3, 0, 3, 1, 2);
    random_phase(30, 30, 1'b1);
    for (int i = 0; i < 6; i++) begin
      period = $urandom_range(2, 80);
      apply_setting(period, $urandom_range(0, period + 8), $urandom_range(0, period + 8),
                    $urandom_range(0, period + 8), $urandom_range(0, period + 8));
      case (i % 4)
        0: random_phase(0, 0, 1'b0);
        1: random_phase(47, 0, 1'b0);
        2: random_phase(0, 47, 1'b0);
        default: random_phase(30, 30, 1'b0);
      endcase
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> servo_esc_pwm_generator.f
src/sepwm_pkg.sv
src/sepwm_front.sv
src/sepwm_queue.sv
src/sepwm_back.sv
src/servo_esc_pwm_generator.sv
tb/sv/servo_esc_pwm_generator_tb.sv
